### src/mac_pkg.sv
// ---------------------------------------------------------------------------
// mac_pkg
// shared types and codes for the moving average crossover block
// ---------------------------------------------------------------------------
`default_nettype none

package mac_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SYMBOL  = 2'd0;
  localparam logic [1:0] REG_SHORT_W = 2'd1;
  localparam logic [1:0] REG_LONG_W  = 2'd2;
  localparam logic [1:0] REG_EPSILON = 2'd3;

  // result codes
  localparam logic       ST_OK     = 1'b0;
  localparam logic       ST_REJECT = 1'b1;

  localparam logic [1:0] SIG_HOLD = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  // register reset values
  localparam logic [15:0] RST_SYMBOL  = 16'd0;
  localparam logic [6:0]  RST_SHORT_W = 7'd5;
  localparam logic [6:0]  RST_LONG_W  = 7'd20;
  localparam logic [15:0] RST_EPSILON = 16'd0;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch the incoming word
    logic check;      // validate tick, push price, set up sweep
    logic sum_step;   // one ring read / accumulate step
    logic div_short;  // start short average division
    logic div_long;   // start long average division
    logic sig;        // evaluate spread and signal
    logic load_out;   // load output register
  } mac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_ok;
    logic sum_done;
    logic div_done;
  } mac_sts_t;

endpackage

`default_nettype wire

### src/mac_div.sv
// ---------------------------------------------------------------------------
// mac_div
// iterative unsigned divider, two quotient bits per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module mac_div #(
  parameter int DVD_W = 47,
  parameter int DVS_W = 7,
  parameter int QUO_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int STEPS = (DVD_W + 1) / 2;
  localparam int SH_W  = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [SH_W-1:0]  q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   r1, r2, r1s, r2s;
  logic             ge1, ge2;

  always_comb begin
    r1  = {rem_r, q_r[SH_W-1]};
    ge1 = r1 >= {1'b0, d_r};
    r1s = ge1 ? (r1 - {1'b0, d_r}) : r1;
    r2  = {r1s[DVS_W-1:0], q_r[SH_W-2]};
    ge2 = r2 >= {1'b0, d_r};
    r2s = ge2 ? (r2 - {1'b0, d_r}) : r2;
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = SH_W'(dividend);
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[SH_W-3:0], ge1, ge2};
      rem_nxt = r2s[DVS_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[QUO_W-1:0];

endmodule

`default_nettype wire

### src/mac_dp.sv
// ---------------------------------------------------------------------------
// mac_dp
// datapath: config registers, price ring, window sums, averages, signal
// ---------------------------------------------------------------------------
`default_nettype none

module mac_dp #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic [15:0]           in_tick_symbol,
  input  wire logic [47:0]           in_tick_time,
  input  wire logic [PRICE_BITS-1:0] in_tick_price,
  input  wire logic [31:0]           in_tick_quantity,
  input  wire mac_pkg::mac_cmd_t     cmd,
  output mac_pkg::mac_sts_t          sts,
  output logic                       out_status,
  output logic [1:0]                 out_trade_signal,
  output logic [39:0]                out_short_average,
  output logic [39:0]                out_long_average
);

  import mac_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = PRICE_BITS + CNT_W;
  localparam int AVG_W = PRICE_BITS + 8;
  localparam int SPR_W = AVG_W + 1;
  localparam int DVD_W = SUM_W + 8;

  function automatic logic [CNT_W-1:0] eff_win(input logic [6:0] w);
    logic [31:0] wx;
    wx = {25'd0, w};
    if (wx == 32'd0) return CNT_W'(1);
    if (wx > 32'(MAX_WINDOW)) return CNT_W'(MAX_WINDOW);
    return CNT_W'(wx);
  endfunction

  // configuration
  logic [15:0] symbol_r, symbol_nxt;
  logic [6:0]  sw_cfg_r, sw_cfg_nxt;
  logic [6:0]  lw_cfg_r, lw_cfg_nxt;
  logic [15:0] eps_r, eps_nxt;

  // latched tick
  logic [15:0]           t_sym_r, t_sym_nxt;
  logic [47:0]           t_time_r, t_time_nxt;
  logic [PRICE_BITS-1:0] t_price_r, t_price_nxt;
  logic [31:0]           t_qty_r, t_qty_nxt;

  // persistent state
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [47:0]             last_time_r, last_time_nxt;
  logic signed [SPR_W-1:0] prev_spr_r, prev_spr_nxt;
  logic                    prev_v_r, prev_v_nxt;

  // per-tick work
  logic                  ok_r, ok_nxt;
  logic [CNT_W-1:0]      sw_r, sw_nxt;
  logic [IDX_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic                  rd_short_r, rd_short_nxt;
  logic [PRICE_BITS-1:0] rdata_r;
  logic [SUM_W-1:0]      long_sum_r, long_sum_nxt;
  logic [SUM_W-1:0]      short_sum_r, short_sum_nxt;
  logic                  div_long_r, div_long_nxt;
  logic [AVG_W-1:0]      savg_r, savg_nxt;
  logic [AVG_W-1:0]      lavg_r, lavg_nxt;
  logic [1:0]            sig_r, sig_nxt;

  // output register
  logic        o_status_r, o_status_nxt;
  logic [1:0]  o_sig_r, o_sig_nxt;
  logic [39:0] o_savg_r, o_savg_nxt;
  logic [39:0] o_lavg_r, o_lavg_nxt;

  logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic                    tick_ok;
  logic [CNT_W-1:0]        lw_eff, sw_eff, fill_new, sw_new;
  logic [CNT_W:0]          fill_inc;
  logic                    rd_issue, mem_we;
  logic                    div_start, div_done;
  logic [DVD_W-1:0]        div_dvd;
  logic [CNT_W-1:0]        div_dvs;
  logic [AVG_W-1:0]        div_quo;
  logic signed [SPR_W-1:0] spread, eps_pos, eps_neg;
  logic [AVG_W+39:0]       savg_ext, lavg_ext;

  assign lw_eff   = eff_win(lw_cfg_r);
  assign sw_eff   = eff_win(sw_cfg_r);
  assign fill_inc = {1'b0, fill_r} + (CNT_W+1)'(1);
  assign fill_new = (fill_inc > {1'b0, lw_eff}) ? lw_eff : fill_inc[CNT_W-1:0];
  assign sw_new   = (sw_eff > fill_new) ? fill_new : sw_eff;

  assign tick_ok = (t_sym_r == symbol_r) && (t_time_r > last_time_r) &&
                   (|t_price_r) && (|t_qty_r);

  assign mem_we   = cmd.check && tick_ok;
  assign rd_issue = cmd.sum_step && (rd_cnt_r < fill_r);

  assign spread  = $signed({1'b0, savg_r}) - $signed({1'b0, lavg_r});
  assign eps_pos = $signed(SPR_W'(eps_r));
  assign eps_neg = -eps_pos;

  assign savg_ext = {40'd0, savg_r};
  assign lavg_ext = {40'd0, lavg_r};

  // shared divider: floor((sum << 8) / count)
  assign div_start = cmd.div_short || cmd.div_long;
  assign div_dvd   = cmd.div_long ? {long_sum_r, 8'd0} : {short_sum_r, 8'd0};
  assign div_dvs   = cmd.div_long ? fill_r : sw_r;

  mac_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W),
    .QUO_W (AVG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    symbol_nxt    = symbol_r;
    sw_cfg_nxt    = sw_cfg_r;
    lw_cfg_nxt    = lw_cfg_r;
    eps_nxt       = eps_r;
    t_sym_nxt     = t_sym_r;
    t_time_nxt    = t_time_r;
    t_price_nxt   = t_price_r;
    t_qty_nxt     = t_qty_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    last_time_nxt = last_time_r;
    prev_spr_nxt  = prev_spr_r;
    prev_v_nxt    = prev_v_r;
    ok_nxt        = ok_r;
    sw_nxt        = sw_r;
    rd_addr_nxt   = rd_addr_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_v_nxt      = 1'b0;
    rd_short_nxt  = rd_short_r;
    long_sum_nxt  = long_sum_r;
    short_sum_nxt = short_sum_r;
    div_long_nxt  = div_long_r;
    savg_nxt      = savg_r;
    lavg_nxt      = lavg_r;
    sig_nxt       = sig_r;
    o_status_nxt  = o_status_r;
    o_sig_nxt     = o_sig_r;
    o_savg_nxt    = o_savg_r;
    o_lavg_nxt    = o_lavg_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL:  symbol_nxt = cfg_wdata;
        REG_SHORT_W: sw_cfg_nxt = cfg_wdata[6:0];
        REG_LONG_W:  lw_cfg_nxt = cfg_wdata[6:0];
        REG_EPSILON: eps_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    if (cmd.accept) begin
      t_sym_nxt   = in_tick_symbol;
      t_time_nxt  = in_tick_time;
      t_price_nxt = in_tick_price;
      t_qty_nxt   = in_tick_quantity;
    end

    if (cmd.check) begin
      ok_nxt = tick_ok;
      if (tick_ok) begin
        last_time_nxt = t_time_r;
        head_nxt      = (head_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_r + IDX_W'(1);
        fill_nxt      = fill_new;
        sw_nxt        = sw_new;
        rd_addr_nxt   = head_r;
        rd_cnt_nxt    = '0;
        long_sum_nxt  = '0;
        short_sum_nxt = '0;
      end
    end

    // newest price first, walking back around the ring
    if (rd_issue) begin
      rd_v_nxt     = 1'b1;
      rd_short_nxt = rd_cnt_r < sw_r;
      rd_cnt_nxt   = rd_cnt_r + CNT_W'(1);
      rd_addr_nxt  = (rd_addr_r == '0) ? IDX_W'(MAX_WINDOW - 1) : rd_addr_r - IDX_W'(1);
    end
    if (rd_v_r) begin
      long_sum_nxt = long_sum_r + SUM_W'(rdata_r);
      if (rd_short_r) begin
        short_sum_nxt = short_sum_r + SUM_W'(rdata_r);
      end
    end

    if (cmd.div_short) div_long_nxt = 1'b0;
    if (cmd.div_long)  div_long_nxt = 1'b1;
    if (div_done) begin
      if (div_long_r) lavg_nxt = div_quo;
      else            savg_nxt = div_quo;
    end

    if (cmd.sig) begin
      sig_nxt = SIG_HOLD;
      if (fill_r >= lw_eff) begin
        if (!prev_v_r) begin
          if (spread > eps_pos)      sig_nxt = SIG_BUY;
          else if (spread < eps_neg) sig_nxt = SIG_SELL;
        end else if (spread > eps_pos && prev_spr_r <= eps_pos) begin
          sig_nxt = SIG_BUY;
        end else if (spread < eps_neg && prev_spr_r >= eps_neg) begin
          sig_nxt = SIG_SELL;
        end
        prev_spr_nxt = spread;
        prev_v_nxt   = 1'b1;
      end
    end

    if (cmd.load_out) begin
      o_status_nxt = ok_r ? ST_OK : ST_REJECT;
      o_sig_nxt    = ok_r ? sig_r : SIG_HOLD;
      o_savg_nxt   = ok_r ? savg_ext[39:0] : 40'd0;
      o_lavg_nxt   = ok_r ? lavg_ext[39:0] : 40'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_r    <= RST_SYMBOL;
      sw_cfg_r    <= RST_SHORT_W;
      lw_cfg_r    <= RST_LONG_W;
      eps_r       <= RST_EPSILON;
      head_r      <= '0;
      fill_r      <= '0;
      last_time_r <= '0;
      prev_spr_r  <= '0;
      prev_v_r    <= 1'b0;
      rd_cnt_r    <= '0;
      rd_v_r      <= 1'b0;
      div_long_r  <= 1'b0;
    end else begin
      symbol_r    <= symbol_nxt;
      sw_cfg_r    <= sw_cfg_nxt;
      lw_cfg_r    <= lw_cfg_nxt;
      eps_r       <= eps_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      last_time_r <= last_time_nxt;
      prev_spr_r  <= prev_spr_nxt;
      prev_v_r    <= prev_v_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      div_long_r  <= div_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_sym_r     <= t_sym_nxt;
    t_time_r    <= t_time_nxt;
    t_price_r   <= t_price_nxt;
    t_qty_r     <= t_qty_nxt;
    ok_r        <= ok_nxt;
    sw_r        <= sw_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_short_r  <= rd_short_nxt;
    long_sum_r  <= long_sum_nxt;
    short_sum_r <= short_sum_nxt;
    savg_r      <= savg_nxt;
    lavg_r      <= lavg_nxt;
    sig_r       <= sig_nxt;
    o_status_r  <= o_status_nxt;
    o_sig_r     <= o_sig_nxt;
    o_savg_r    <= o_savg_nxt;
    o_lavg_r    <= o_lavg_nxt;
  end

  // price ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[head_r] <= t_price_r;
    end
    if (rd_issue) begin
      rdata_r <= ring_mem[rd_addr_r];
    end
  end

  assign sts.tick_ok  = tick_ok;
  assign sts.sum_done = (rd_cnt_r == fill_r) && !rd_v_r;
  assign sts.div_done = div_done;

  assign out_status        = o_status_r;
  assign out_trade_signal  = o_sig_r;
  assign out_short_average = o_savg_r;
  assign out_long_average  = o_lavg_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  a_sweep_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && tick_ok) |=> (sw_r <= fill_r && fill_r != '0 && rd_cnt_r == '0))
    else $error("bad sweep setup after accepted tick");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (rd_cnt_r <= fill_r && $past(rd_cnt_r) < fill_r))
    else $error("ring sweep read past held prices");

endmodule

`default_nettype wire

### src/mac_ctrl.sv
// ---------------------------------------------------------------------------
// mac_ctrl
// controller: sequences check, ring sweep, divisions, signal and result hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module mac_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mac_pkg::mac_cmd_t      cmd,
  input  wire mac_pkg::mac_sts_t sts
);

  import mac_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_WAITS = 4'd3;
  localparam logic [3:0] S_WAITL = 4'd4;
  localparam logic [3:0] S_SIG   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.tick_ok ? S_SUM : S_DONE;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          cmd.div_short = 1'b1;
          state_nxt     = S_WAITS;
        end
      end
      S_WAITS: begin
        if (sts.div_done) begin
          cmd.div_long = 1'b1;
          state_nxt    = S_WAITL;
        end
      end
      S_WAITL: begin
        if (sts.div_done) state_nxt = S_SIG;
      end
      S_SIG: begin
        cmd.sig   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)     out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_CHECK)
    else $error("accepted word not checked next cycle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside hand-off state");

  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_WAITS || state_r == S_WAITL))
    else $error("divider finished outside a division phase");

endmodule

`default_nettype wire

### src/moving_average_crossover_signal_top.sv
// ---------------------------------------------------------------------------
// moving_average_crossover_signal_top
// moving average crossover: validates ticks, keeps a price window, gives
// short/long averages with 8 fraction bits and a buy/sell/hold signal
// ---------------------------------------------------------------------------
//
//   channel  handshake               word
//   -------  ----------------------  ------------------------------------------
//   cfg      cfg_we                  cfg_index, cfg_wdata (no read-back)
//   in       in_valid / in_stall     tick symbol, time, price, quantity
//   out      out_valid / out_stall   status, trade signal, short/long average
//
// one tick at a time; an accepted tick holds the block through the ring
//   sweep (one read a cycle), the short and long divisions on the shared
//   divider, the signal step and the hand-off
// a rejected tick goes straight from the check to the hand-off
// reset is synchronous; config reloads to defaults, window and history clear,
//   the ring itself is not cleared (entries are only read once written)
// the output register lets a new tick in while the last result is stalled
// ---------------------------------------------------------------------------
`default_nettype none

module moving_average_crossover_signal_top #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata,
  // tick input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_tick_symbol,
  input  wire logic [47:0]           in_tick_time,
  input  wire logic [PRICE_BITS-1:0] in_tick_price,
  input  wire logic [31:0]           in_tick_quantity,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_status,
  output logic [1:0]                 out_trade_signal,
  output logic [39:0]                out_short_average,
  output logic [39:0]                out_long_average
);

  import mac_pkg::*;

  mac_cmd_t cmd;
  mac_sts_t sts;

  // sequencer: idle -> check -> ring sweep -> two divisions -> signal -> hand-off
  mac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // config, price ring, sums, shared divider, spread tracking, output register
  mac_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_tick_symbol    (in_tick_symbol),
    .in_tick_time      (in_tick_time),
    .in_tick_price     (in_tick_price),
    .in_tick_quantity  (in_tick_quantity),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_trade_signal  (out_trade_signal),
    .out_short_average (out_short_average),
    .out_long_average  (out_long_average)
  );

endmodule

`default_nettype wire
